// File: design/ratacc_pkg.sv
// Shared types and constants of the rational accumulator.
`timescale 1ns / 1ps
`default_nettype none
package ratacc_pkg;

	localparam int MAG_W  = 32;
	localparam int PROD_W = 64;

	localparam logic [2:0] OP_LOAD = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef enum logic {
		MODE_GCD = 1'b0,
		MODE_DIV = 1'b1
	} euc_mode_t;

	typedef struct packed {
		logic      start;
		euc_mode_t mode;
	} euc_req_t;

	typedef struct packed {
		logic busy;
		logic fin;
	} core_sts_t;

endpackage
`default_nettype wire

// File: design/ratacc_euc.sv
// Shared iterative unit: binary GCD or restoring division on 64-bit magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module ratacc_euc
	import ratacc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire euc_req_t          req,
	input  wire logic [PROD_W-1:0] x,
	input  wire logic [PROD_W-1:0] y,
	output logic                   done,
	output logic [PROD_W-1:0]      res
);

	localparam int CNT_W = $clog2(PROD_W);

	typedef enum logic [3:0] {
		P_IDLE = 4'b0001,
		P_TWOS = 4'b0010,
		P_RUN  = 4'b0100,
		P_DIV  = 4'b1000
	} phase_t;

	phase_t              phase_q;
	logic [PROD_W-1:0]   x_q, y_q, r_q, res_q;
	logic [CNT_W-1:0]    k_q, cnt_q;
	logic                done_q;
	logic [PROD_W:0]     sub_a, sub_b;
	logic [PROD_W+1:0]   diff;
	logic                ge;

	always_comb begin
		if (phase_q == P_DIV) begin
			sub_a = {r_q, x_q[PROD_W-1]};
		end else begin
			sub_a = {1'b0, x_q};
		end
		sub_b = {1'b0, y_q};
		diff  = {1'b0, sub_a} - {1'b0, sub_b};
		ge    = ~diff[PROD_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			r_q     <= '0;
			res_q   <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (req.start) begin
						x_q     <= x;
						y_q     <= y;
						r_q     <= '0;
						k_q     <= '0;
						cnt_q   <= '0;
						phase_q <= (req.mode == MODE_DIV) ? P_DIV : P_TWOS;
					end
				end
				P_TWOS: begin
					if (x_q == '0) begin
						res_q   <= y_q;
						done_q  <= 1'b1;
						phase_q <= P_IDLE;
					end else if (y_q == '0) begin
						res_q   <= x_q;
						done_q  <= 1'b1;
						phase_q <= P_IDLE;
					end else if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + 1'b1;
					end else begin
						phase_q <= P_RUN;
					end
				end
				P_RUN: begin
					priority if (x_q == '0) begin
						res_q   <= y_q << k_q;
						done_q  <= 1'b1;
						phase_q <= P_IDLE;
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (ge) begin
						x_q <= diff[PROD_W-1:0];
					end else begin
						x_q <= y_q;
						y_q <= x_q;
					end
				end
				P_DIV: begin
					r_q   <= ge ? diff[PROD_W-1:0] : sub_a[PROD_W-1:0];
					x_q   <= {x_q[PROD_W-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(PROD_W - 1)) begin
						res_q   <= {x_q[PROD_W-2:0], ge};
						done_q  <= 1'b1;
						phase_q <= P_IDLE;
					end
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

// File: design/ratacc_core.sv
// Sequencer, accumulator and multiplier of the rational accumulator.
`timescale 1ns / 1ps
`default_nettype none
module ratacc_core
	import ratacc_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [2:0]                    opcode,
	input  wire logic signed [MAG_W-1:0]       operand_num,
	input  wire logic signed [MAG_W-1:0]       operand_den,
	input  wire logic                          out_free,
	output core_sts_t                          sts,
	output logic signed [DATA_WIDTH-1:0]       acc_num,
	output logic signed [DATA_WIDTH-1:0]       acc_den,
	output status_t                            status,
	output euc_req_t                           euc_req,
	output logic [PROD_W-1:0]                  euc_x,
	output logic [PROD_W-1:0]                  euc_y,
	input  wire logic                          euc_done,
	input  wire logic [PROD_W-1:0]             euc_res
);

	localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << (DATA_WIDTH - 1);

	typedef enum logic [12:0] {
		C_IDLE = 13'b0000000000001,
		C_G1   = 13'b0000000000010,
		C_DA   = 13'b0000000000100,
		C_DB   = 13'b0000000001000,
		C_M1   = 13'b0000000010000,
		C_M2   = 13'b0000000100000,
		C_M3   = 13'b0000001000000,
		C_ADD  = 13'b0000010000000,
		C_G2   = 13'b0000100000000,
		C_DN   = 13'b0001000000000,
		C_DM   = 13'b0010000000000,
		C_CHK  = 13'b0100000000000,
		C_DONE = 13'b1000000000000
	} cstate_t;

	cstate_t                       state_q;
	logic                          go_q;
	logic [2:0]                    op_q;
	logic                          c_neg_q, d_neg_q, a_neg_q, b_neg_q;
	logic [MAG_W-1:0]              c_mag_q, d_mag_q, a_mag_q, b_mag_q;
	logic                          n_neg_q, m_neg_q, t_neg_q;
	logic [PROD_W-1:0]             n_mag_q, m_mag_q, t_mag_q, g_q;
	status_t                       status_q;
	logic signed [DATA_WIDTH-1:0]  acc_num_q, acc_den_q;

	logic signed [MAG_W-1:0]       an_ext, ad_ext;
	logic [MAG_W-1:0]              an_mag, ad_mag, in_c_mag, in_d_mag;
	logic [MAG_W-1:0]              mul_x, mul_y;
	logic [PROD_W-1:0]             prod;
	logic                          t_eff_neg, n_fits, m_fits;

	always_comb begin
		an_ext   = MAG_W'(acc_num_q);
		ad_ext   = MAG_W'(acc_den_q);
		an_mag   = an_ext[MAG_W-1] ? MAG_W'(-an_ext) : MAG_W'(an_ext);
		ad_mag   = ad_ext[MAG_W-1] ? MAG_W'(-ad_ext) : MAG_W'(ad_ext);
		in_c_mag = operand_num[MAG_W-1] ? MAG_W'(-operand_num) : MAG_W'(operand_num);
		in_d_mag = operand_den[MAG_W-1] ? MAG_W'(-operand_den) : MAG_W'(operand_den);

		mul_x = a_mag_q;
		mul_y = (op_q == OP_MUL) ? c_mag_q : d_mag_q;
		if (state_q == C_M2) begin
			mul_x = b_mag_q;
			mul_y = (op_q == OP_MUL) ? d_mag_q : c_mag_q;
		end else if (state_q == C_M3) begin
			mul_x = b_mag_q;
			mul_y = d_mag_q;
		end
		prod = PROD_W'(mul_x) * PROD_W'(mul_y);

		t_eff_neg = (op_q == OP_SUB) ? ~t_neg_q : t_neg_q;
		n_fits = (n_mag_q == '0) || (n_neg_q ? (n_mag_q <= LIM) : (n_mag_q < LIM));
		m_fits = (m_mag_q == '0) || (m_neg_q ? (m_mag_q <= LIM) : (m_mag_q < LIM));

		unique case (state_q)
			C_G1: begin
				euc_x = PROD_W'(a_mag_q);
				euc_y = PROD_W'(b_mag_q);
			end
			C_DA: begin
				euc_x = PROD_W'(a_mag_q);
				euc_y = g_q;
			end
			C_DB: begin
				euc_x = PROD_W'(b_mag_q);
				euc_y = g_q;
			end
			C_G2: begin
				euc_x = n_mag_q;
				euc_y = m_mag_q;
			end
			C_DN: begin
				euc_x = n_mag_q;
				euc_y = g_q;
			end
			default: begin
				euc_x = m_mag_q;
				euc_y = g_q;
			end
		endcase
		euc_req.start = go_q;
		euc_req.mode  = (state_q == C_G1 || state_q == C_G2) ? MODE_GCD : MODE_DIV;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= C_IDLE;
			go_q      <= 1'b0;
			op_q      <= OP_LOAD;
			c_neg_q   <= 1'b0;
			d_neg_q   <= 1'b0;
			a_neg_q   <= 1'b0;
			b_neg_q   <= 1'b0;
			c_mag_q   <= '0;
			d_mag_q   <= '0;
			a_mag_q   <= '0;
			b_mag_q   <= '0;
			n_neg_q   <= 1'b0;
			m_neg_q   <= 1'b0;
			t_neg_q   <= 1'b0;
			n_mag_q   <= '0;
			m_mag_q   <= '0;
			t_mag_q   <= '0;
			g_q       <= '0;
			status_q  <= ST_OK;
			acc_num_q <= '0;
			acc_den_q <= DATA_WIDTH'(1);
		end else begin
			go_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						op_q     <= opcode;
						c_neg_q  <= operand_num[MAG_W-1];
						d_neg_q  <= operand_den[MAG_W-1];
						c_mag_q  <= in_c_mag;
						d_mag_q  <= in_d_mag;
						a_neg_q  <= an_ext[MAG_W-1];
						b_neg_q  <= ad_ext[MAG_W-1];
						a_mag_q  <= an_mag;
						b_mag_q  <= ad_mag;
						status_q <= ST_OK;
						priority if (opcode > OP_DIV) begin
							state_q <= C_DONE;
						end else if (opcode == OP_LOAD) begin
							n_neg_q <= operand_num[MAG_W-1];
							m_neg_q <= operand_den[MAG_W-1];
							n_mag_q <= PROD_W'(in_c_mag);
							m_mag_q <= PROD_W'(in_d_mag);
							go_q    <= 1'b1;
							state_q <= C_G2;
						end else begin
							go_q    <= 1'b1;
							state_q <= C_G1;
						end
					end
				end
				C_G1: begin
					if (euc_done) begin
						if (euc_res == '0) begin
							status_q <= ST_ZERO;
							state_q  <= C_DONE;
						end else begin
							g_q     <= euc_res;
							go_q    <= 1'b1;
							state_q <= C_DA;
						end
					end
				end
				C_DA: begin
					if (euc_done) begin
						a_mag_q <= euc_res[MAG_W-1:0];
						go_q    <= 1'b1;
						state_q <= C_DB;
					end
				end
				C_DB: begin
					if (euc_done) begin
						b_mag_q <= euc_res[MAG_W-1:0];
						state_q <= C_M1;
					end
				end
				C_M1: begin
					n_mag_q <= prod;
					n_neg_q <= a_neg_q ^ ((op_q == OP_MUL) ? c_neg_q : d_neg_q);
					state_q <= C_M2;
				end
				C_M2: begin
					if (op_q == OP_ADD || op_q == OP_SUB) begin
						t_mag_q <= prod;
						t_neg_q <= c_neg_q ^ b_neg_q;
						state_q <= C_M3;
					end else begin
						m_mag_q <= prod;
						m_neg_q <= b_neg_q ^ ((op_q == OP_MUL) ? d_neg_q : c_neg_q);
						go_q    <= 1'b1;
						state_q <= C_G2;
					end
				end
				C_M3: begin
					m_mag_q <= prod;
					m_neg_q <= b_neg_q ^ d_neg_q;
					state_q <= C_ADD;
				end
				C_ADD: begin
					priority if (n_neg_q == t_eff_neg) begin
						n_mag_q <= n_mag_q + t_mag_q;
					end else if (n_mag_q >= t_mag_q) begin
						n_mag_q <= n_mag_q - t_mag_q;
					end else begin
						n_mag_q <= t_mag_q - n_mag_q;
						n_neg_q <= t_eff_neg;
					end
					go_q    <= 1'b1;
					state_q <= C_G2;
				end
				C_G2: begin
					if (euc_done) begin
						if (euc_res == '0) begin
							status_q <= ST_ZERO;
							state_q  <= C_DONE;
						end else begin
							g_q     <= euc_res;
							go_q    <= 1'b1;
							state_q <= C_DN;
						end
					end
				end
				C_DN: begin
					if (euc_done) begin
						n_mag_q <= euc_res;
						go_q    <= 1'b1;
						state_q <= C_DM;
					end
				end
				C_DM: begin
					if (euc_done) begin
						m_mag_q <= euc_res;
						state_q <= C_CHK;
					end
				end
				C_CHK: begin
					if (n_fits && m_fits) begin
						acc_num_q <= n_neg_q ? -$signed(n_mag_q[DATA_WIDTH-1:0])
						                     : $signed(n_mag_q[DATA_WIDTH-1:0]);
						acc_den_q <= m_neg_q ? -$signed(m_mag_q[DATA_WIDTH-1:0])
						                     : $signed(m_mag_q[DATA_WIDTH-1:0]);
					end else begin
						status_q <= ST_OVF;
					end
					state_q <= C_DONE;
				end
				C_DONE: begin
					if (out_free) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign sts.busy = (state_q != C_IDLE);
	assign sts.fin  = (state_q == C_DONE);
	assign acc_num  = acc_num_q;
	assign acc_den  = acc_den_q;
	assign status   = status_q;

endmodule
`default_nettype wire

// File: design/rational_accumulator_unit.sv
// Top level of the rational accumulator.
//
// Holds a signed fraction num/den, 0/1 after reset. Each input transaction carries
// an opcode (load, add, subtract, multiply, divide) and an operand fraction. Unless
// loading, the accumulator is reduced by its GCD, the operation applied with 64-bit
// products, the result reduced again and stored; one output transaction follows per
// input transaction, with the new fraction, sign flags and status (zero over zero
// or overflow leave the accumulator unchanged). Unused opcodes return the
// value as is.
//
// The run time is data dependent: one shared GCD/divide unit runs each binary GCD
// and each of the up to four 64-bit divisions in turn, plus the multiply and add
// steps. A load needs one GCD and two divisions; an unused opcode goes straight
// to its result without the GCD/divide unit.
// in_stall is high from acceptance until the result moves into the output
// register; one transaction is in flight at a time. A stalled result holds in
// the output register; the next input is taken meanwhile, and its result waits
// until the register is freed. Reset clears the accumulator to 0/1 and empties
// the output register.
`timescale 1ns / 1ps
`default_nettype none
module rational_accumulator_unit
	import ratacc_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [2:0]              opcode,
	input  wire logic signed [31:0]      operand_num,
	input  wire logic signed [31:0]      operand_den,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [31:0]           result_num,
	output logic signed [31:0]           result_den,
	output logic                         positive_flag,
	output logic                         negative_flag,
	output logic [1:0]                   status
);

	core_sts_t                     sts;
	logic signed [DATA_WIDTH-1:0]  acc_num, acc_den;
	status_t                       core_status;
	euc_req_t                      euc_req;
	logic [PROD_W-1:0]             euc_x, euc_y, euc_res;
	logic                          euc_done;
	logic                          out_valid_q, pos_q;
	logic signed [31:0]            res_num_q, res_den_q;
	logic [1:0]                    status_q;
	logic                          pos, load;

	ratacc_core #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_valid & ~in_stall),
		.opcode     (opcode),
		.operand_num(operand_num),
		.operand_den(operand_den),
		.out_free   (~out_valid_q),
		.sts        (sts),
		.acc_num    (acc_num),
		.acc_den    (acc_den),
		.status     (core_status),
		.euc_req    (euc_req),
		.euc_x      (euc_x),
		.euc_y      (euc_y),
		.euc_done   (euc_done),
		.euc_res    (euc_res)
	);

	ratacc_euc u_euc (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (euc_req),
		.x     (euc_x),
		.y     (euc_y),
		.done  (euc_done),
		.res   (euc_res)
	);

	assign pos  = (!acc_num[DATA_WIDTH-1] && acc_num != '0 &&
	               !acc_den[DATA_WIDTH-1] && acc_den != '0) ||
	              (acc_num[DATA_WIDTH-1] && acc_den[DATA_WIDTH-1]);
	assign load = sts.fin & ~out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_num_q   <= '0;
			res_den_q   <= '0;
			pos_q       <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				res_num_q   <= 32'(acc_num);
				res_den_q   <= 32'(acc_den);
				pos_q       <= pos;
				status_q    <= core_status;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall      = sts.busy;
	assign out_valid     = out_valid_q;
	assign result_num    = res_num_q;
	assign result_den    = res_den_q;
	assign positive_flag = pos_q;
	assign negative_flag = ~pos_q;
	assign status        = status_q;

endmodule
`default_nettype wire

// File: design/ratacc_chk.sv
// Port checker for the rational accumulator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ratacc_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic [2:0]         opcode,
	input wire logic signed [31:0] operand_num,
	input wire logic signed [31:0] operand_den,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [31:0] result_num,
	input wire logic signed [31:0] result_den,
	input wire logic               positive_flag,
	input wire logic               negative_flag,
	input wire logic [1:0]         status
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a transaction is in flight");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> positive_flag != negative_flag)
		else $error("sign flags not complementary");

	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && positive_flag |-> result_num != 0 && result_den != 0)
		else $error("positive flag on a zero part");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_num) &&
		$stable(result_den) && $stable(status))
		else $error("stalled result changed");

endmodule

bind rational_accumulator_unit ratacc_chk u_ratacc_chk (.*);
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the rational accumulator: directed table, then random traffic.
`timescale 1ns / 1ps
module tb;
	import ratacc_pkg::*;

	typedef struct {
		logic [2:0]         op;
		logic signed [31:0] num;
		logic signed [31:0] den;
		bit                 fixed;
		logic signed [31:0] x_num;
		logic signed [31:0] x_den;
		status_t            x_st;
	} row_t;

	typedef struct {
		logic signed [31:0] num;
		logic signed [31:0] den;
		logic               pos;
		logic               neg;
		status_t            st;
	} frac_res_t;

	localparam int WATCHDOG = 20000;
	localparam int N_RANDOM = 400;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         opcode = '0;
	logic signed [31:0] operand_num = '0;
	logic signed [31:0] operand_den = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] result_num;
	logic signed [31:0] result_den;
	logic               positive_flag;
	logic               negative_flag;
	logic [1:0]         status;

	logic signed [63:0] acc_n = 0;
	logic signed [63:0] acc_d = 1;
	frac_res_t          pending_fracs[$];
	int                 errors = 0;
	int                 n_sent = 0;
	int                 n_got = 0;
	int                 idle_cnt = 0;
	bit                 quiet = 1'b0;
	bit                 stim_done = 1'b0;
	bit                 hold_long = 1'b0;
	int                 op_seen[8];
	row_t               dir_rows[$];

	rational_accumulator_unit #(.DATA_WIDTH(32)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .operand_num(operand_num), .operand_den(operand_den),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_num(result_num), .result_den(result_den),
		.positive_flag(positive_flag), .negative_flag(negative_flag), .status(status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] mag_gcd(input logic [63:0] x, input logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic logic [63:0] absv(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic bit in_range(input logic signed [63:0] v);
		return v >= -64'sd2147483648 && v <= 64'sd2147483647;
	endfunction

	// 128-bit signed arithmetic avoids any overflow of the double-width products
	function automatic frac_res_t fraction_step(input logic [2:0] op,
			input logic signed [31:0] c32, input logic signed [31:0] d32);
		frac_res_t r;
		logic signed [127:0] a, b, c, d, n, m, g;
		logic [63:0] g0;
		status_t st;
		st = ST_OK;
		c = c32;
		d = d32;
		g0 = mag_gcd(absv(acc_n), absv(acc_d));
		a = acc_n;
		b = acc_d;
		if (op <= OP_DIV) begin
			if (g0 == 0 && op != OP_LOAD) st = ST_ZERO;
			else begin
				if (g0 != 0) begin
					a = a / $signed({64'd0, g0});
					b = b / $signed({64'd0, g0});
				end
				case (op)
					OP_LOAD: begin n = c; m = d; end
					OP_ADD:  begin n = a * d + c * b; m = b * d; end
					OP_SUB:  begin n = a * d - c * b; m = b * d; end
					OP_MUL:  begin n = a * c; m = b * d; end
					default: begin n = a * d; m = b * c; end
				endcase
				g = mag_gcd(64'(n < 0 ? -n : n), 64'(m < 0 ? -m : m));
				if (g == 0) st = ST_ZERO;
				else begin
					n = n / g;
					m = m / g;
					if (!in_range(64'(n)) || !in_range(64'(m))) st = ST_OVF;
					else begin
						acc_n = 64'(n);
						acc_d = 64'(m);
					end
				end
			end
		end
		r.num = acc_n[31:0];
		r.den = acc_d[31:0];
		r.pos = (acc_n > 0 && acc_d > 0) || (acc_n < 0 && acc_d < 0);
		r.neg = !r.pos;
		r.st  = st;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp);
		$display("MISMATCH result %0d %s: got %0d expected %0d", n_got, what, got, exp);
		errors++;
	endtask

	task automatic send_fraction(input logic [2:0] op, input logic signed [31:0] c,
			input logic signed [31:0] d);
		int gap;
		frac_res_t r;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		operand_num <= c;
		operand_den <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = fraction_step(op, c, d);
		pending_fracs.push_back(r);
		op_seen[op]++;
		n_sent++;
	endtask

	task automatic add_row(input logic [2:0] op, input logic signed [31:0] c,
			input logic signed [31:0] d, input bit fx = 0,
			input logic signed [31:0] xn = 0, input logic signed [31:0] xd = 0,
			input status_t xs = ST_OK);
		row_t rw;
		rw.op = op; rw.num = c; rw.den = d; rw.fixed = fx;
		rw.x_num = xn; rw.x_den = xd; rw.x_st = xs;
		dir_rows.push_back(rw);
	endtask

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 20) - 10;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			2: return $urandom_range(0, 2000) - 1000;
			3: return $signed($urandom);
			default: return $urandom_range(0, 200000) - 100000;
		endcase
	endfunction

	// Result side: random stalls, one long hold-off, check in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_fracs.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					frac_res_t e;
					e = pending_fracs.pop_front();
					if (result_num !== e.num) report_mismatch("num", result_num, e.num);
					if (result_den !== e.den) report_mismatch("den", result_den, e.den);
					if (positive_flag !== e.pos)
						report_mismatch("positive_flag", positive_flag, e.pos);
					if (negative_flag !== e.neg)
						report_mismatch("negative_flag", negative_flag, e.neg);
					if (status !== e.st) report_mismatch("status", status, e.st);
				end
				n_got++;
			end
		end
	end

	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_stall <= 1'b1;
				for (hold = 0; hold < 1500; hold++) @(posedge clk);
				hold_long = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_long) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG) begin
			$display("Watchdog expired after %0d idle cycles", idle_cnt);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int i, k;
		logic [2:0] op;
		frac_res_t r;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset, 0/1 read back through multiply and unused opcode
		add_row(OP_MUL, 5, 7, 1, 0, 1, ST_OK);
		add_row(3'd5, 1, 1, 1, 0, 1, ST_OK);
		add_row(OP_LOAD, 6, 4, 1, 3, 2, ST_OK);
		add_row(OP_ADD, 1, 3);
		add_row(OP_SUB, -7, 5);
		add_row(OP_MUL, -2, 9);
		add_row(OP_DIV, 3, -4);
		add_row(OP_LOAD, 5, 0, 1, 1, 0, ST_OK);
		add_row(OP_LOAD, -5, 0, 1, -1, 0, ST_OK);
		add_row(OP_LOAD, 0, 0, 1, -1, 0, ST_ZERO);
		add_row(OP_LOAD, 0, 9, 1, 0, 1, ST_OK);
		add_row(OP_MUL, 0, 0, 1, 0, 1, ST_ZERO);
		add_row(OP_LOAD, 32'sh7fffffff, 1, 1, 32'sh7fffffff, 1, ST_OK);
		add_row(OP_ADD, 1, 1, 1, 32'sh7fffffff, 1, ST_OVF);
		add_row(OP_LOAD, 32'sh80000000, 1, 1, 32'sh80000000, 1, ST_OK);
		add_row(OP_MUL, -1, 1, 1, 32'sh80000000, 1, ST_OVF);
		add_row(OP_DIV, 1, 32'sh80000000);
		add_row(OP_LOAD, 3, -6);
		add_row(3'd7, 32'sh80000000, 32'sh7fffffff);
		add_row(OP_LOAD, 32'sh80000000, 32'sh80000000);
		add_row(OP_SUB, 32'sh7fffffff, 32'sh7fffffff);
		add_row(3'd6, -1, -1);

		foreach (dir_rows[j]) begin
			send_fraction(dir_rows[j].op, dir_rows[j].num, dir_rows[j].den);
			if (dir_rows[j].fixed) begin
				r = pending_fracs[$];
				if (r.num !== dir_rows[j].x_num)
					report_mismatch("table num", r.num, dir_rows[j].x_num);
				if (r.den !== dir_rows[j].x_den)
					report_mismatch("table den", r.den, dir_rows[j].x_den);
				if (r.st !== dir_rows[j].x_st)
					report_mismatch("table status", r.st, dir_rows[j].x_st);
			end
		end

		for (i = 0; i < N_RANDOM; i++) begin
			if (i == 100) hold_long = 1'b1;
			if (i == N_RANDOM - 60) quiet = 1'b1;
			k = $urandom_range(0, 99);
			if (k < 12) op = OP_LOAD;
			else if (k < 97) op = 3'($urandom_range(OP_ADD, OP_DIV));
			else op = 3'($urandom_range(5, 7));
			send_fraction(op, rand_val(), rand_val());
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;

		while (pending_fracs.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		$display("Covered %0d transactions: load %0d add %0d sub %0d mul %0d div %0d",
			n_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
		$display("Extremes, zero over zero, overflow, zero denominators, long output hold-off");
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// File: sim.f
design/ratacc_pkg.sv
design/ratacc_euc.sv
design/ratacc_core.sv
design/rational_accumulator_unit.sv
design/ratacc_chk.sv
bench/tb.sv
